FILE: rtl/kpsd_pkg.sv
// Shared types, constants and the segment decode table for the keypad scanner and display.
`default_nettype none
package kpsd_pkg;

   // Digit code that shows nothing.
   localparam logic [4:0] CODE_BLANK = 5'h10;

   // Drive bytes (active low) and the segment byte that lights nothing.
   localparam logic [7:0] DRIVE_NONE  = 8'hFF;
   localparam logic [7:0] DRIVE_PROBE = 8'h00;
   localparam logic [7:0] SEG_DARK    = 8'hFF;

   // Register indexes on the configuration port.
   localparam logic REG_DWELL    = 1'b0;
   localparam logic REG_DEBOUNCE = 1'b1;

   // Reset values of the registers.
   localparam logic [7:0] DWELL_RESET    = 8'd3;
   localparam logic [3:0] DEBOUNCE_RESET = 4'd2;

   // One result beat.
   typedef struct packed {
      logic [7:0] seg_out;
      logic [7:0] drive_out;
      logic       key_valid;
      logic [3:0] key_code;
      logic [2:0] key_slot;
   } rsp_type;

   // Active-low segment pattern for a digit code: hex digits, then blank.
   function automatic logic [7:0] seg_pattern(input logic [4:0] code);
      logic [7:0] pat;
      unique case (code)
         5'd0:    pat = 8'hC0;
         5'd1:    pat = 8'hF9;
         5'd2:    pat = 8'hA4;
         5'd3:    pat = 8'hB0;
         5'd4:    pat = 8'h99;
         5'd5:    pat = 8'h92;
         5'd6:    pat = 8'h82;
         5'd7:    pat = 8'hF8;
         5'd8:    pat = 8'h80;
         5'd9:    pat = 8'h90;
         5'd10:   pat = 8'h88;
         5'd11:   pat = 8'h83;
         5'd12:   pat = 8'hC6;
         5'd13:   pat = 8'hA1;
         5'd14:   pat = 8'h86;
         5'd15:   pat = 8'h8E;
         default: pat = SEG_DARK;
      endcase
      return pat;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/keypad_scan_display_mux.sv
// A tick beat's result beat enters the result queue at the edge that accepts the tick.
// Throughput: one tick beat per cycle while the result queue has room; the sequencer
// updates state once per beat; the two-entry queue takes input while a result waits.
// Reset (synchronous, active high): idle probe phase, counters cleared, all digits blank,
// segment latch dark, dwell 3 ticks, debounce 2 frames, result queue empty.
`default_nettype none
module keypad_scan_display_mux #(
   parameter int NUM_DIGITS = 8
) (
   input  wire         clock,
   input  wire         reset,
   // Tick beats: tdata holds return_lines [1:0], zeros above.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,
   // Result beats: tdata holds seg_out [7:0], drive_out [15:8], key_code [19:16],
   // key_slot [22:20], zero [23]; tuser holds key_valid [0].
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic [0:0]  rsp_tuser,
   // Configuration port.
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import kpsd_pkg::*;

   localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic [IDX_W-1:0] LAST_DIGIT = IDX_W'(NUM_DIGITS - 1);

   typedef enum logic [2:0] {
      PH_IDLE_PROBE    = 3'd0,
      PH_IDLE_REFRESH  = 3'd1,
      PH_DEB_REFRESH   = 3'd2,
      PH_CONFIRM_PROBE = 3'd3,
      PH_ROW_WALK      = 3'd4,
      PH_REL_PROBE     = 3'd5,
      PH_REL_REFRESH   = 3'd6
   } phase_type;

   // Registers.
   logic [7:0]       dwell_ticks_ff;
   logic [3:0]       debounce_ff;
   phase_type        phase_ff, phase_in;
   logic             probe_pending_ff, probe_pending_in;
   logic [IDX_W-1:0] digit_index_ff, digit_index_in;
   logic [7:0]       dwell_count_ff, dwell_count_in;
   logic [3:0]       frame_count_ff, frame_count_in;
   logic [2:0]       row_index_ff, row_index_in;
   logic [3:0]       found_code_ff, found_code_in;
   logic [IDX_W-1:0] write_slot_ff, write_slot_in;
   logic [7:0]       seg_latch_ff, seg_latch_in;
   logic [4:0]       digit_codes_ff [NUM_DIGITS];

   logic             tick;
   logic             cfg_write;
   logic             code_write;
   logic [1:0]       down;
   logic             fifo_ready;
   rsp_type          rsp_in;
   rsp_type          rsp_out;

   assign tick      = req_tvalid && req_tready;
   assign down      = ~req_tdata[1:0];
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Configuration port: always ready, reads return the register.
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[2])
         REG_DWELL:    csr_prdata = {24'd0, dwell_ticks_ff};
         REG_DEBOUNCE: csr_prdata = {28'd0, debounce_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ticks_ff <= DWELL_RESET;
         debounce_ff    <= DEBOUNCE_RESET;
      end else if (cfg_write) begin
         unique case (csr_paddr[2])
            REG_DWELL:    dwell_ticks_ff <= csr_pwdata[7:0];
            REG_DEBOUNCE: debounce_ff    <= csr_pwdata[3:0];
            default:      dwell_ticks_ff <= dwell_ticks_ff;
         endcase
      end
   end

   // One scan tick: first take the probe answer, then run this tick's phase.
   always_comb begin
      logic [7:0]       dwell;
      logic [3:0]       need;
      logic [4:0]       frame_next;
      logic [7:0]       seg;
      logic [7:0]       drive;
      logic             kvalid;
      logic [3:0]       kcode;
      logic [2:0]       kslot;

      phase_in         = phase_ff;
      probe_pending_in = probe_pending_ff;
      digit_index_in   = digit_index_ff;
      dwell_count_in   = dwell_count_ff;
      frame_count_in   = frame_count_ff;
      row_index_in     = row_index_ff;
      found_code_in    = found_code_ff;
      write_slot_in    = write_slot_ff;
      seg_latch_in     = seg_latch_ff;
      code_write       = 1'b0;
      seg              = seg_latch_ff;
      drive            = DRIVE_NONE;
      kvalid           = 1'b0;
      kcode            = 4'd0;
      kslot            = 3'd0;

      // Answer to last tick's probe or row drive.
      if (probe_pending_ff) begin
         probe_pending_in = 1'b0;
         unique case (phase_ff)
            PH_IDLE_PROBE: begin
               phase_in       = (down != 2'b00) ? PH_DEB_REFRESH : PH_IDLE_REFRESH;
               digit_index_in = '0;
               dwell_count_in = 8'd0;
               frame_count_in = 4'd0;
            end
            PH_CONFIRM_PROBE: begin
               if (down != 2'b00) begin
                  phase_in     = PH_ROW_WALK;
                  row_index_in = 3'd0;
               end else begin
                  phase_in = PH_IDLE_PROBE;
               end
            end
            PH_ROW_WALK: begin
               if (down != 2'b00) begin
                  found_code_in = {down[1], row_index_ff};
                  phase_in      = PH_REL_PROBE;
               end else if (row_index_ff == 3'd7) begin
                  phase_in = PH_IDLE_PROBE;
               end else begin
                  row_index_in = row_index_ff + 3'd1;
               end
            end
            PH_REL_PROBE: begin
               if (down != 2'b00) begin
                  phase_in       = PH_REL_REFRESH;
                  digit_index_in = '0;
                  dwell_count_in = 8'd0;
                  frame_count_in = 4'd0;
               end else begin
                  // Key released: report it and store it in the next slot.
                  kvalid        = 1'b1;
                  kcode         = found_code_ff;
                  kslot         = 3'(write_slot_ff);
                  code_write    = 1'b1;
                  write_slot_in = (write_slot_ff == LAST_DIGIT) ? '0
                                                                : write_slot_ff + 1'b1;
                  phase_in      = PH_IDLE_PROBE;
               end
            end
            default: phase_in = PH_IDLE_PROBE;
         endcase
      end

      // This tick's activity.
      dwell      = (dwell_ticks_ff == 8'd0) ? 8'd1 : dwell_ticks_ff;
      need       = ((phase_in == PH_REL_REFRESH) || (debounce_ff == 4'd0)) ? 4'd1
                                                                           : debounce_ff;
      frame_next = {1'b0, frame_count_in} + 5'd1;
      unique case (phase_in)
         PH_IDLE_REFRESH, PH_DEB_REFRESH, PH_REL_REFRESH: begin
            if (dwell_count_in < dwell) begin
               // Digit lit.
               seg_latch_in   = seg_pattern(digit_codes_ff[digit_index_in]);
               seg            = seg_latch_in;
               drive          = ~(8'd1 << digit_index_in);
               dwell_count_in = dwell_count_in + 8'd1;
            end else begin
               // Blank tick, then move to the next digit or end the frame.
               dwell_count_in = 8'd0;
               if (digit_index_in == LAST_DIGIT) begin
                  digit_index_in = '0;
                  if (frame_next >= {1'b0, need}) begin
                     frame_count_in = 4'd0;
                     if (phase_in == PH_IDLE_REFRESH) begin
                        phase_in = PH_IDLE_PROBE;
                     end else if (phase_in == PH_DEB_REFRESH) begin
                        phase_in = PH_CONFIRM_PROBE;
                     end else begin
                        phase_in = PH_REL_PROBE;
                     end
                  end else begin
                     frame_count_in = frame_next[3:0];
                  end
               end else begin
                  digit_index_in = digit_index_in + 1'b1;
               end
            end
         end
         PH_ROW_WALK: begin
            drive            = ~(8'd1 << row_index_in);
            probe_pending_in = 1'b1;
         end
         PH_CONFIRM_PROBE, PH_REL_PROBE: begin
            drive            = DRIVE_PROBE;
            probe_pending_in = 1'b1;
         end
         default: begin
            phase_in         = PH_IDLE_PROBE;
            drive            = DRIVE_PROBE;
            probe_pending_in = 1'b1;
         end
      endcase

      rsp_in.seg_out   = seg;
      rsp_in.drive_out = drive;
      rsp_in.key_valid = kvalid;
      rsp_in.key_code  = kcode;
      rsp_in.key_slot  = kslot;
   end

   // Sequencer state advances once per accepted tick beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE_PROBE;
         probe_pending_ff <= 1'b0;
         digit_index_ff   <= '0;
         dwell_count_ff   <= 8'd0;
         frame_count_ff   <= 4'd0;
         row_index_ff     <= 3'd0;
         found_code_ff    <= 4'd0;
         write_slot_ff    <= '0;
         seg_latch_ff     <= SEG_DARK;
      end else if (tick) begin
         phase_ff         <= phase_in;
         probe_pending_ff <= probe_pending_in;
         digit_index_ff   <= digit_index_in;
         dwell_count_ff   <= dwell_count_in;
         frame_count_ff   <= frame_count_in;
         row_index_ff     <= row_index_in;
         found_code_ff    <= found_code_in;
         write_slot_ff    <= write_slot_in;
         seg_latch_ff     <= seg_latch_in;
      end
   end

   // Digit code store, blank after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_codes_ff[i] <= CODE_BLANK;
         end
      end else if (tick && code_write) begin
         digit_codes_ff[write_slot_ff] <= {1'b0, found_code_ff};
      end
   end

   // Result queue.
   assign req_tready = fifo_ready;

   kpsd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (fifo_ready),
      .in_data   (rsp_in),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_out)
   );

   assign rsp_tdata = {1'b0, rsp_out.key_slot, rsp_out.key_code,
                       rsp_out.drive_out, rsp_out.seg_out};
   assign rsp_tuser = rsp_out.key_valid;

`ifndef SYNTHESIS
   // A key is reported only on the tick that starts a new all-rows probe.
   a_key_with_probe : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[15:8] == DRIVE_PROBE))
      else $error("key reported without an all-rows probe drive");

   // A pending probe answer is only ever awaited from a probing phase.
   a_pending_phase : assert property (@(posedge clock) disable iff (reset)
      probe_pending_ff |-> (phase_ff == PH_IDLE_PROBE || phase_ff == PH_CONFIRM_PROBE ||
                            phase_ff == PH_ROW_WALK || phase_ff == PH_REL_PROBE))
      else $error("probe answer pending outside a probing phase");

   // Digit and slot pointers stay inside the display.
   a_index_range : assert property (@(posedge clock) disable iff (reset)
      (digit_index_ff <= LAST_DIGIT) && (write_slot_ff <= LAST_DIGIT))
      else $error("digit pointer beyond the last digit");

   // A refresh phase never leaves a probe answer pending on the next tick.
   a_refresh_no_probe : assert property (@(posedge clock) disable iff (reset)
      (tick && (phase_in == PH_IDLE_REFRESH || phase_in == PH_DEB_REFRESH ||
                phase_in == PH_REL_REFRESH)) |=> !probe_pending_ff)
      else $error("probe pending after a refresh tick");
`endif

endmodule
`default_nettype wire

FILE: rtl/kpsd_rsp_fifo.sv
// Two-entry result queue that decouples the scan sequencer from the result channel.
`default_nettype none
module kpsd_rsp_fifo (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  kpsd_pkg::rsp_type   in_data,
   output logic                out_valid,
   input  wire                 out_ready,
   output kpsd_pkg::rsp_type   out_data
);
   import kpsd_pkg::*;

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // Handshake status comes straight from the fill count.
   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire
